FILE: rtl/dwr_pkg.sv
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types and codes for the double-ended queue with reverse.
// ----------------------------------------------------------------------------
package dwr_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [2:0] FUNC_REVERSE    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pop_value;
        logic [4:0]         fill_count;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

endpackage

FILE: rtl/deque_with_reverse.sv
// ----------------------------------------------------------------------------
// deque_with_reverse
// Bounded double-ended queue of signed 32-bit words in a ring store.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one request per item,
// push back, push front, pop back, pop front or reverse. Reverse only flips
// a direction flag, so front and back swap without moving entries.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one
// result per request with status, popped word and fill count.
// A request is accepted in the idle state, where the store read is registered;
// the update and the result register load happen in the execute state, and
// only then is the next request taken. The result register lets a new request
// be taken while the previous result waits. If the receiver stalls with a
// result still held, the next request waits in its execute cycle until the
// result register frees.
// Reset (synchronous, active low) empties the queue and clears the reverse
// flag; store contents are not cleared and a word read is only used once written.
// A push into a full queue is dropped and flagged; a pop on empty returns 0.
// ----------------------------------------------------------------------------
module deque_with_reverse #(
    parameter int DEPTH = dwr_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dwr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dwr_pkg::t_out_item o_out_item
);
    import dwr_pkg::*;

    t_cmd cmd;

    dwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dwr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

FILE: rtl/dwr_ctrl.sv
// ----------------------------------------------------------------------------
// dwr_ctrl
// Controller: takes a request, runs it through the datapath, holds the
// result valid until the receiver takes it.
// ----------------------------------------------------------------------------
module dwr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dwr_pkg::t_cmd o_cmd
);
    import dwr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign exec        = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = '{accept: accept, exec: exec};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/dwr_dp.sv
// ----------------------------------------------------------------------------
// dwr_dp
// Datapath: ring store, front index, count, reverse flag, result register.
// ----------------------------------------------------------------------------
module dwr_dp #(
    parameter int DEPTH = dwr_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dwr_pkg::t_cmd      i_cmd,
    input  dwr_pkg::t_in_item  i_in_item,
    output dwr_pkg::t_out_item o_out_item
);
    import dwr_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;
    logic [2:0]    r_func;
    logic [31:0]   r_value;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    t_out_item     r_out, n_out;

    logic [IW-1:0] front_inc, front_dec, back_addr, tail_addr, rd_addr, wr_addr;
    logic [CW:0]   sum_back, sum_tail;
    logic          in_pop_front, is_push, at_front, full, empty, do_write;

    // ring arithmetic
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + IW'(1);
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);

    assign sum_back  = (CW + 1)'(r_front) + (CW + 1)'(r_count) - (CW + 1)'(1);
    assign back_addr = (r_count == '0) ? r_front :
                       (sum_back >= DEPTH_W) ? IW'(sum_back - DEPTH_W) : IW'(sum_back);
    assign sum_tail  = (CW + 1)'(r_front) + (CW + 1)'(r_count);
    assign tail_addr = (sum_tail >= DEPTH_W) ? IW'(sum_tail - DEPTH_W) : IW'(sum_tail);

    assign empty = (r_count == '0);
    assign full  = ((CW + 1)'(r_count) >= DEPTH_W);

    // read address chosen at accept from the incoming request
    assign in_pop_front = ((i_in_item.func == FUNC_POP_FRONT) && !r_rev) ||
                          ((i_in_item.func == FUNC_POP_BACK) && r_rev);
    assign rd_addr      = in_pop_front ? r_front : back_addr;

    assign is_push  = (r_func == FUNC_PUSH_BACK) || (r_func == FUNC_PUSH_FRONT);
    assign at_front = is_push ? ((r_func == FUNC_PUSH_FRONT) ^ r_rev)
                              : ((r_func == FUNC_POP_FRONT) ^ r_rev);
    assign wr_addr  = at_front ? front_dec : tail_addr;
    assign do_write = i_cmd.exec && is_push && !full;

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_rev   = r_rev;
        n_out   = '{status: ST_OK, pop_value: '0, fill_count: '0};
        case (r_func)
            FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    if (at_front) n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_POP_BACK, FUNC_POP_FRONT: begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.pop_value = r_rd_data;
                    if (at_front) n_front = front_inc;
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) n_front = '0;
                end
            end
            FUNC_REVERSE: begin
                n_rev = !r_rev;
            end
            default: ;
        endcase
        n_out.fill_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_in_item.func;
            r_value   <= i_in_item.push_value;
            r_rd_data <= r_mem[rd_addr];
        end
        if (do_write) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    assign o_out_item = r_out;

endmodule
